FILE: rtl/vqdm_pkg.sv
`timescale 1ns / 1ps
package vqdm_pkg;

    localparam int QUEUE_DEPTH = 256;
    localparam int IDX_W = 8;
    localparam int LINK_W = 9;
    localparam int CNT_W = 16;
    localparam logic [LINK_W-1:0] LINK_NONE = 9'd256;

    localparam logic [2:0] MODE_INIT  = 3'd0;
    localparam logic [2:0] MODE_ALLOC = 3'd1;
    localparam logic [2:0] MODE_WRITE = 3'd2;
    localparam logic [2:0] MODE_PUB   = 3'd3;
    localparam logic [2:0] MODE_FREE  = 3'd4;
    localparam logic [2:0] MODE_POST  = 3'd5;
    localparam logic [2:0] MODE_TAKE  = 3'd6;
    localparam logic [2:0] MODE_NOP   = 3'd7;

    typedef struct packed {
        logic       latch;     // capture input item
        logic       init_start;
        logic       init_step; // write one chain entry
        logic       exec;      // apply the operation (memory read data ready)
        logic       finish;    // present result
    } vqdm_cmd_t;

    typedef struct packed {
        logic       init_last;
    } vqdm_stat_t;

endpackage

FILE: rtl/vqdm_ctrl.sv
`timescale 1ns / 1ps
module vqdm_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [2:0]          mode,
    input  vqdm_pkg::vqdm_stat_t stat,
    output vqdm_pkg::vqdm_cmd_t  cmd,
    output logic                busy
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_INIT = 2'd2;

    logic [1:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_INIT;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.latch = 1'b1;
                    if (mode == vqdm_pkg::MODE_INIT)
                    begin
                        cmd.init_start = 1'b1;
                        state_next = ST_INIT;
                    end
                    else
                        state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            ST_INIT:
            begin
                cmd.init_step = 1'b1;
                if (stat.init_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

FILE: rtl/vqdm_datapath.sv
`timescale 1ns / 1ps
module vqdm_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  vqdm_pkg::vqdm_cmd_t  cmd,
    output vqdm_pkg::vqdm_stat_t stat,
    input  logic                 in_reset_init,
    input  logic [8:0]           size_cfg,
    input  logic [2:0]           mode,
    input  logic [7:0]           desc_index,
    input  logic [63:0]          buffer_addr,
    input  logic [31:0]          buffer_len,
    input  logic [15:0]          desc_flags,
    input  logic [31:0]          used_length,
    output logic                 done,
    output logic [7:0]           result_index,
    output logic                 index_valid,
    output logic [31:0]          result_length,
    output logic                 used_pending,
    output logic [8:0]           free_count
);

    // descriptor and ring memories
    logic [8:0]  link_mem [vqdm_pkg::QUEUE_DEPTH];
    logic [63:0] addr_mem [vqdm_pkg::QUEUE_DEPTH];
    logic [31:0] len_mem  [vqdm_pkg::QUEUE_DEPTH];
    logic [15:0] flag_mem [vqdm_pkg::QUEUE_DEPTH];
    logic [7:0]  avail_mem[vqdm_pkg::QUEUE_DEPTH];
    logic [7:0]  uid_mem  [vqdm_pkg::QUEUE_DEPTH];
    logic [31:0] ulen_mem [vqdm_pkg::QUEUE_DEPTH];

    logic [2:0]  mode_reg;
    logic [7:0]  idx_reg;
    logic [63:0] addr_reg;
    logic [31:0] blen_reg, ulen_reg;
    logic [15:0] flags_reg;
    logic [8:0]  active_reg, free_head_reg, free_total_reg, init_ptr_reg;
    logic [15:0] avail_cnt_reg, used_cnt_reg, taken_cnt_reg;
    logic [7:0]  avail_slot_reg, used_slot_reg, taken_slot_reg;
    logic [8:0]  link_rd_reg;
    logic [7:0]  uid_rd_reg;
    logic [31:0] ulen_rd_reg;
    logic        done_reg, valid_reg;
    logic [7:0]  ridx_reg;
    logic [31:0] rlen_reg;

    logic [8:0]  clamped;
    logic        alloc_ok, write_ok, free_ok, post_ok, take_ok;
    logic [15:0] used_diff;
    logic        res_valid;
    logic [7:0]  res_index;
    logic [31:0] res_length;

    assign clamped = (size_cfg == 9'd0) ? 9'd1 :
                     (size_cfg > 9'd256) ? 9'd256 : size_cfg;

    // ring slot = counter mod active size, tracked alongside the counter;
    // back to 0 when the 16-bit counter wraps
    function automatic logic [7:0] slot_step(input logic [15:0] c, input logic [7:0] s,
                                             input logic [8:0] n);
        logic [8:0] s1;
        s1 = {1'b0, s} + 9'd1;
        return ((c == 16'hFFFF) || (s1 == n)) ? 8'd0 : s1[7:0];
    endfunction

    assign used_diff  = used_cnt_reg - taken_cnt_reg;

    assign alloc_ok = (free_total_reg != 9'd0) && (free_head_reg < active_reg);
    assign write_ok = ({1'b0, idx_reg} < active_reg);
    assign free_ok  = write_ok && (free_total_reg < active_reg);
    assign post_ok  = ({7'd0, active_reg} > used_diff);
    assign take_ok  = (used_cnt_reg != taken_cnt_reg);

    assign stat.init_last = (init_ptr_reg + 9'd1 >= active_reg);

    always_comb
    begin
        res_valid  = 1'b0;
        res_index  = '0;
        res_length = '0;
        if (cmd.exec)
        begin
            case (mode_reg)
                vqdm_pkg::MODE_ALLOC:
                    if (alloc_ok)
                    begin
                        res_valid = 1'b1;
                        res_index = free_head_reg[7:0];
                    end
                vqdm_pkg::MODE_TAKE:
                    if (take_ok)
                    begin
                        res_valid  = 1'b1;
                        res_index  = uid_rd_reg;
                        res_length = ulen_rd_reg;
                    end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg  <= mode;
            idx_reg   <= desc_index;
            addr_reg  <= buffer_addr;
            blen_reg  <= buffer_len;
            flags_reg <= desc_flags;
            ulen_reg  <= used_length;
        end
        link_rd_reg <= link_mem[free_head_reg[7:0]];
        uid_rd_reg  <= uid_mem[taken_slot_reg];
        ulen_rd_reg <= ulen_mem[taken_slot_reg];
        if (cmd.init_step)
        begin
            link_mem[init_ptr_reg[7:0]] <= stat.init_last ? vqdm_pkg::LINK_NONE
                                                          : init_ptr_reg + 9'd1;
            flag_mem[init_ptr_reg[7:0]] <= '0;
        end
        else if (cmd.exec)
        begin
            case (mode_reg)
                vqdm_pkg::MODE_WRITE:
                    if (write_ok)
                    begin
                        addr_mem[idx_reg] <= addr_reg;
                        len_mem[idx_reg]  <= blen_reg;
                        flag_mem[idx_reg] <= flags_reg;
                        link_mem[idx_reg] <= vqdm_pkg::LINK_NONE;
                    end
                vqdm_pkg::MODE_PUB:
                    avail_mem[avail_slot_reg] <= idx_reg;
                vqdm_pkg::MODE_FREE:
                    if (free_ok)
                        link_mem[idx_reg] <= free_head_reg;
                vqdm_pkg::MODE_POST:
                    if (post_ok)
                    begin
                        uid_mem[used_slot_reg]  <= idx_reg;
                        ulen_mem[used_slot_reg] <= ulen_reg;
                    end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 9'd256;
            free_head_reg  <= '0;
            free_total_reg <= 9'd256;
            init_ptr_reg   <= '0;
            avail_cnt_reg  <= '0;
            used_cnt_reg   <= '0;
            taken_cnt_reg  <= '0;
            avail_slot_reg <= '0;
            used_slot_reg  <= '0;
            taken_slot_reg <= '0;
            done_reg       <= 1'b0;
            valid_reg      <= 1'b0;
            ridx_reg       <= '0;
            rlen_reg       <= '0;
        end
        else
        begin
            done_reg <= cmd.finish && !in_reset_init;
            if (cmd.finish)
            begin
                valid_reg <= res_valid;
                ridx_reg  <= res_index;
                rlen_reg  <= res_length;
            end
            if (cmd.init_start)
            begin
                active_reg     <= clamped;
                free_total_reg <= clamped;
                init_ptr_reg   <= '0;
                free_head_reg  <= '0;
                avail_cnt_reg  <= '0;
                used_cnt_reg   <= '0;
                taken_cnt_reg  <= '0;
                avail_slot_reg <= '0;
                used_slot_reg  <= '0;
                taken_slot_reg <= '0;
            end
            if (cmd.init_step)
                init_ptr_reg <= stat.init_last ? 9'd0 : init_ptr_reg + 9'd1;
            if (cmd.exec)
            begin
                case (mode_reg)
                    vqdm_pkg::MODE_ALLOC:
                        if (alloc_ok)
                        begin
                            free_head_reg  <= link_rd_reg;
                            free_total_reg <= free_total_reg - 9'd1;
                        end
                    vqdm_pkg::MODE_PUB:
                    begin
                        avail_cnt_reg  <= avail_cnt_reg + 16'd1;
                        avail_slot_reg <= slot_step(avail_cnt_reg, avail_slot_reg,
                                                    active_reg);
                    end
                    vqdm_pkg::MODE_FREE:
                        if (free_ok)
                        begin
                            free_head_reg  <= {1'b0, idx_reg};
                            free_total_reg <= free_total_reg + 9'd1;
                        end
                    vqdm_pkg::MODE_POST:
                        if (post_ok)
                        begin
                            used_cnt_reg  <= used_cnt_reg + 16'd1;
                            used_slot_reg <= slot_step(used_cnt_reg, used_slot_reg,
                                                       active_reg);
                        end
                    vqdm_pkg::MODE_TAKE:
                        if (take_ok)
                        begin
                            taken_cnt_reg  <= taken_cnt_reg + 16'd1;
                            taken_slot_reg <= slot_step(taken_cnt_reg, taken_slot_reg,
                                                        active_reg);
                        end
                    default: ;
                endcase
            end
        end
    end

    assign done          = done_reg;
    assign result_index  = ridx_reg;
    assign index_valid   = valid_reg;
    assign result_length = rlen_reg;
    assign used_pending  = (used_cnt_reg != taken_cnt_reg);
    assign free_count    = free_total_reg;

endmodule

FILE: rtl/virtqueue_descriptor_manager_unit.sv
`timescale 1ns / 1ps
// Split virtqueue manager, driver side. Pulse start with an operation while
// busy is low; the transaction is taken at that edge. Exactly one result per
// transaction appears for one cycle with done high; there is no backpressure,
// so sample it then. Ordinary operations do one descriptor-table read, then
// the update, and busy stays high until the update is done, so a new start is
// taken only after that. Init walks the link table one entry per cycle, size
// being the written size clamped to 1..256, and its result follows the last
// entry. After reset the same walk runs over all 256 entries with busy high
// and no result. The size register (cfg_wdata) is applied on init only.
module virtqueue_descriptor_manager_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic [2:0]  mode,
    input  logic [7:0]  desc_index,
    input  logic [63:0] buffer_addr,
    input  logic [31:0] buffer_len,
    input  logic [15:0] desc_flags,
    input  logic [31:0] used_length,
    output logic        done,
    output logic [7:0]  result_index,
    output logic        index_valid,
    output logic [31:0] result_length,
    output logic        used_pending,
    output logic [8:0]  free_count
);

    vqdm_pkg::vqdm_cmd_t  cmd;
    vqdm_pkg::vqdm_stat_t stat;
    logic [8:0] qsize_reg;
    logic       boot_reg;   // high during the post-reset chain walk

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qsize_reg <= 9'd256;
            boot_reg  <= 1'b1;
        end
        else
        begin
            if (cfg_we)
                qsize_reg <= cfg_wdata;
            if (cmd.finish)
                boot_reg <= 1'b0;
        end
    end

    vqdm_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    vqdm_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_reset_init (boot_reg),
        .size_cfg      (qsize_reg),
        .mode          (mode),
        .desc_index    (desc_index),
        .buffer_addr   (buffer_addr),
        .buffer_len    (buffer_len),
        .desc_flags    (desc_flags),
        .used_length   (used_length),
        .done          (done),
        .result_index  (result_index),
        .index_valid   (index_valid),
        .result_length (result_length),
        .used_pending  (used_pending),
        .free_count    (free_count)
    );

endmodule

FILE: verif/vqdm_checker.sv
`timescale 1ns / 1ps
module vqdm_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic [2:0]  mode,
    input  logic [7:0]  desc_index,
    input  logic [31:0] used_length,
    input  logic        done,
    input  logic [7:0]  result_index,
    input  logic        index_valid,
    input  logic [31:0] result_length,
    input  logic        used_pending,
    input  logic [8:0]  free_count,
    output int          fail_count,
    output int          pending_count,
    output int          done_count
);

    typedef struct packed {
        logic [7:0]  index;
        logic        valid;
        logic [31:0] length;
        logic        pending;
        logic [8:0]  free;
    } vq_result_t;

    vq_result_t         result_q[$];

    logic [8:0]         size_reg;
    logic [8:0]         live_size;
    logic [vqdm_pkg::LINK_W-1:0] link_tbl[vqdm_pkg::QUEUE_DEPTH];
    logic [8:0]         head;
    logic [8:0]         n_free;
    logic [vqdm_pkg::CNT_W-1:0] avail_cnt;
    logic [vqdm_pkg::CNT_W-1:0] used_cnt;
    logic [vqdm_pkg::CNT_W-1:0] taken_cnt;
    logic [7:0]         used_id_tbl[vqdm_pkg::QUEUE_DEPTH];
    logic [31:0]        used_len_tbl[vqdm_pkg::QUEUE_DEPTH];

    assign pending_count = result_q.size();

    // Rebuild the free chain at the latched size (clamped 1..256).
    function automatic void rebuild_chain();
        begin
            live_size = (size_reg == 0) ? 9'd1 : (size_reg > 9'd256 ? 9'd256 : size_reg);
            for (int i = 0; i < vqdm_pkg::QUEUE_DEPTH; i++)
            begin
                if (i < live_size)
                    link_tbl[i] = (i + 1 < live_size) ? 9'(i + 1) : vqdm_pkg::LINK_NONE;
            end
            head = 0;
            n_free = live_size;
            avail_cnt = 0;
            used_cnt = 0;
            taken_cnt = 0;
        end
    endfunction

    // Apply one transaction and return the result it should produce.
    function automatic vq_result_t apply_op(logic [2:0] op, logic [7:0] idx, logic [31:0] ulen);
        vq_result_t r;
        logic [15:0] slot;
        begin
            r = '0;
            case (op)
                vqdm_pkg::MODE_INIT: rebuild_chain();
                vqdm_pkg::MODE_ALLOC:
                    if (n_free != 0 && head < live_size)
                    begin
                        r.index = head[7:0];
                        r.valid = 1'b1;
                        head = link_tbl[head[7:0]];
                        n_free = n_free - 1;
                    end
                vqdm_pkg::MODE_WRITE:
                    if (idx < live_size)
                        link_tbl[idx] = vqdm_pkg::LINK_NONE;
                vqdm_pkg::MODE_PUB: avail_cnt = avail_cnt + 1;
                vqdm_pkg::MODE_FREE:
                    if (idx < live_size && n_free < live_size)
                    begin
                        link_tbl[idx] = head;
                        head = {1'b0, idx};
                        n_free = n_free + 1;
                    end
                vqdm_pkg::MODE_POST:
                    if (16'(used_cnt - taken_cnt) < live_size)
                    begin
                        slot = used_cnt % live_size;
                        used_id_tbl[slot[7:0]] = idx;
                        used_len_tbl[slot[7:0]] = ulen;
                        used_cnt = used_cnt + 1;
                    end
                vqdm_pkg::MODE_TAKE:
                    if (used_cnt != taken_cnt)
                    begin
                        slot = taken_cnt % live_size;
                        r.index = used_id_tbl[slot[7:0]];
                        r.length = used_len_tbl[slot[7:0]];
                        r.valid = 1'b1;
                        taken_cnt = taken_cnt + 1;
                    end
                default: ;
            endcase
            r.pending = (used_cnt != taken_cnt);
            r.free = n_free;
            return r;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        vq_result_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            done_count <= 0;
            result_q.delete();
            size_reg = 9'd256;
            rebuild_chain();
        end
        else
        begin
            if (done)
            begin
                done_count <= done_count + 1;
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result idx=%0d valid=%0d", $time,
                             result_index, index_valid);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (want !== {result_index, index_valid, result_length,
                                  used_pending, free_count})
                    begin
                        $display("%0t: mismatch exp idx=%0d v=%0d len=%h pend=%0d free=%0d",
                                 $time, want.index, want.valid, want.length,
                                 want.pending, want.free);
                        $display("%0t:          act idx=%0d v=%0d len=%h pend=%0d free=%0d",
                                 $time, result_index, index_valid, result_length,
                                 used_pending, free_count);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_we)
                size_reg = cfg_wdata;
            if (start && !busy)
                result_q.push_back(apply_op(mode, desc_index, used_length));
        end
    end

endmodule

FILE: verif/tb_virtqueue_descriptor_manager_unit.sv
`timescale 1ns / 1ps
module tb_virtqueue_descriptor_manager_unit;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        cfg_we = 1'b0;
    logic [8:0]  cfg_wdata = '0;
    logic [2:0]  mode = vqdm_pkg::MODE_INIT;
    logic [7:0]  desc_index = '0;
    logic [63:0] buffer_addr = '0;
    logic [31:0] buffer_len = '0;
    logic [15:0] desc_flags = '0;
    logic [31:0] used_length = '0;
    logic        done;
    logic [7:0]  result_index;
    logic        index_valid;
    logic [31:0] result_length;
    logic        used_pending;
    logic [8:0]  free_count;
    int          fail_count;
    int          pending_count;
    int          done_count;

    // Driver-side bookkeeping: current clamped size, items sent, burst length.
    logic [8:0]  cur_size;
    int          sent_count;
    int          burst_left;

    always #2 clk = ~clk;

    virtqueue_descriptor_manager_unit i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .mode(mode),
        .desc_index(desc_index), .buffer_addr(buffer_addr),
        .buffer_len(buffer_len), .desc_flags(desc_flags),
        .used_length(used_length), .done(done), .result_index(result_index),
        .index_valid(index_valid), .result_length(result_length),
        .used_pending(used_pending), .free_count(free_count)
    );

    vqdm_checker i_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .mode(mode),
        .desc_index(desc_index),
        .used_length(used_length), .done(done), .result_index(result_index),
        .index_valid(index_valid), .result_length(result_length),
        .used_pending(used_pending), .free_count(free_count),
        .fail_count(fail_count), .pending_count(pending_count),
        .done_count(done_count)
    );

    // Hard stop; worst case is well under 1 ms of sim time.
    initial
    begin
        #4ms;
        $display("== FAIL ==");
        $finish;
    end

    // Drive one transaction: hold start until the handshake edge, then
    // either keep start high for a back-to-back item or drop it.
    // Called at a falling edge; busy is stable until the next rising edge.
    task automatic send_op(input logic [2:0] op, input logic [7:0] idx,
                           input logic [63:0] addr, input logic [31:0] blen,
                           input logic [15:0] flg, input logic [31:0] ulen);
        logic was_busy;
        begin
            mode <= op;
            desc_index <= idx;
            buffer_addr <= addr;
            buffer_len <= blen;
            desc_flags <= flg;
            used_length <= ulen;
            start <= 1'b1;
            do
            begin
                was_busy = busy;
                @(posedge clk);
                if (was_busy)
                    @(negedge clk);
            end
            while (was_busy);
            @(negedge clk);
            sent_count++;
            // bursts: stay high into the next item, else insert a gap
            if (burst_left > 0)
                burst_left--;
            else
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                burst_left = $urandom_range(0, 12);
            end
        end
    endtask

    task automatic send_rand(input logic [2:0] op, input logic [7:0] idx);
        begin
            send_op(op, idx, {$urandom, $urandom}, $urandom, 16'($urandom), $urandom);
        end
    endtask

    // Quiesce, write the size register, then init so the new size takes effect.
    // The wait before the write covers any tail activity.
    task automatic resize(input logic [8:0] sz);
        begin
            start <= 1'b0;
            while (pending_count != 0) @(negedge clk);
            repeat (300) @(negedge clk);
            cfg_we <= 1'b1;
            cfg_wdata <= sz;
            @(negedge clk);
            cfg_we <= 1'b0;
            cur_size = (sz == 0) ? 9'd1 : (sz > 9'd256 ? 9'd256 : sz);
            send_rand(vqdm_pkg::MODE_INIT, 8'd0);
        end
    endtask

    // Random mix: alloc, write, publish, device posts, take, free, nop, init.
    task automatic rand_item();
        int pick;
        logic [7:0] idx;
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 3) == 0)
                idx = 8'($urandom);
            else
                idx = 8'($urandom_range(0, cur_size - 1));
            if (pick < 20)       send_rand(vqdm_pkg::MODE_ALLOC, idx);
            else if (pick < 35)  send_rand(vqdm_pkg::MODE_WRITE, idx);
            else if (pick < 47)  send_rand(vqdm_pkg::MODE_PUB, idx);
            else if (pick < 62)  send_rand(vqdm_pkg::MODE_POST, idx);
            else if (pick < 77)  send_rand(vqdm_pkg::MODE_TAKE, idx);
            else if (pick < 94)  send_rand(vqdm_pkg::MODE_FREE, idx);
            else if (pick < 97)  send_rand(vqdm_pkg::MODE_NOP, idx);
            else                 send_rand(vqdm_pkg::MODE_INIT, idx);
        end
    endtask

    initial
    begin
        cur_size = 9'd256;
        sent_count = 0;
        burst_left = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, every mode but init, empty and full corner cases.
        send_op(vqdm_pkg::MODE_TAKE, 8'd0, '0, '0, '0, '0);    // take with none pending
        send_op(vqdm_pkg::MODE_FREE, 8'd5, '0, '0, '0, '0);    // free when all free
        send_op(vqdm_pkg::MODE_ALLOC, 8'd0, '0, '0, '0, '0);
        send_op(vqdm_pkg::MODE_WRITE, 8'd0, '1, '1, '1, '1);
        send_op(vqdm_pkg::MODE_WRITE, 8'd255, '0, '0, '0, '0);
        send_op(vqdm_pkg::MODE_PUB, 8'd255, '0, '0, '0, '0);
        send_op(vqdm_pkg::MODE_POST, 8'd255, '0, '0, '0, 32'hFFFF_FFFF);
        send_op(vqdm_pkg::MODE_POST, 8'd0, '0, '0, '0, 32'h0);
        send_op(vqdm_pkg::MODE_TAKE, 8'd0, '0, '0, '0, '0);
        send_op(vqdm_pkg::MODE_TAKE, 8'd0, '0, '0, '0, '0);
        send_op(vqdm_pkg::MODE_FREE, 8'd0, '0, '0, '0, '0);
        send_op(vqdm_pkg::MODE_NOP, 8'hAA, '0, '0, '0, '0);

        // Tiny queue: exhaust allocs, out-of-range write/free, used ring full,
        // and a double free that corrupts the chain.
        resize(9'd2);
        send_rand(vqdm_pkg::MODE_ALLOC, 8'd0);
        send_rand(vqdm_pkg::MODE_ALLOC, 8'd0);
        send_rand(vqdm_pkg::MODE_ALLOC, 8'd0);
        send_rand(vqdm_pkg::MODE_WRITE, 8'd7);
        send_rand(vqdm_pkg::MODE_FREE, 8'd9);
        send_rand(vqdm_pkg::MODE_POST, 8'd1);
        send_rand(vqdm_pkg::MODE_POST, 8'd2);
        send_rand(vqdm_pkg::MODE_POST, 8'd3);
        send_rand(vqdm_pkg::MODE_FREE, 8'd1);
        send_rand(vqdm_pkg::MODE_FREE, 8'd1);
        send_rand(vqdm_pkg::MODE_ALLOC, 8'd0);
        send_rand(vqdm_pkg::MODE_ALLOC, 8'd0);
        resize(9'd0);
        send_rand(vqdm_pkg::MODE_ALLOC, 8'd0);
        send_rand(vqdm_pkg::MODE_PUB, 8'd3);

        // Random phases over several sizes, extremes included.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: resize(9'd4);
                1: resize(9'd1);
                2: resize(9'd16);
                3: resize(9'd511);
                4: resize(9'd37);
                default: resize(9'd256);
            endcase
            repeat (105) rand_item();
        end

        start <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        $display("Sent %0d transactions, %0d results checked, sizes 0..511.",
                 sent_count, done_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
